// ===== hw/rtl/positional_list_engine_core_macros.svh =====
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ple_pkg.sv =====
// Operation and status codes of the positional list engine.
package ple_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_CLEAR     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

// ===== hw/rtl/ple_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/positional_list_engine_core.sv =====
// Top level of the positional list engine: sequencer, link and data memories, result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_operation, s_value, s_position
//  m_       | out       | m_valid / m_ready  | m_status, m_count, m_head_value, m_tail_value
//
// One operation at a time. Errors, clear and the unused code go from S_DECODE to S_DONE;
// front inserts pass S_POP (free chain only) and S_INSERT, front deletes S_DEL_FRONT,
// then S_DEL_HEAD if any node is left; later positions walk the next-link memory in S_WALK.
// Reset clears the pointers and counters; the node memories need no clearing pass.
// A result waiting in the output register does not block acceptance of the next item;
// the sequencer holds only when a second result is ready and the first is still untaken.
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int POOL_DEPTH = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_operation,
    input  logic signed [DATA_WIDTH-1:0]         s_value,
    input  logic [$clog2(POOL_DEPTH+2)-1:0]      s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [$clog2(POOL_DEPTH+2)-1:0]      m_count,
    output logic signed [DATA_WIDTH-1:0]         m_head_value,
    output logic signed [DATA_WIDTH-1:0]         m_tail_value
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 2);
    localparam int PTR_W = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_INSERT,
        S_WALK,
        S_INS_LINK,
        S_DEL_FRONT,
        S_DEL_HEAD,
        S_DEL_NEXT,
        S_DEL_FREE,
        S_DONE
    } state_t;

    state_t                  state_reg,   state_next;
    op_t                     op_reg,      op_next;
    status_t                 status_reg,  status_next;
    logic [DATA_WIDTH-1:0]   value_reg,   value_next;
    logic [CNT_W-1:0]        pos_reg,     pos_next;
    logic [CNT_W-1:0]        tgt_reg,     tgt_next;
    logic [PTR_W-1:0]        first_reg,   first_next;
    logic [PTR_W-1:0]        last_reg,    last_next;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [PTR_W-1:0]        free_reg,    free_next;
    logic [PTR_W-1:0]        fresh_reg,   fresh_next;
    logic [DATA_WIDTH-1:0]   head_reg,    head_next;
    logic [DATA_WIDTH-1:0]   tail_reg,    tail_next;
    logic [PTR_W-1:0]        ptr_reg,     ptr_next;
    logic [CNT_W-1:0]        steps_reg,   steps_next;
    logic [IDX_W-1:0]        node_reg,    node_next;
    logic                    ins_reg,     ins_next;
    logic                    tail_ld_reg, tail_ld_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [CNT_W-1:0]        m_count_reg, m_count_next;
    logic [DATA_WIDTH-1:0]   m_head_reg,  m_head_next;
    logic [DATA_WIDTH-1:0]   m_tail_reg,  m_tail_next;

    logic [CNT_W-1:0]        eff_pos;

    logic                    lk_wr_en, lk_rd_en;
    logic [IDX_W-1:0]        lk_wr_addr, lk_rd_addr;
    logic [PTR_W-1:0]        lk_wr_data, lk_rd_data;
    logic                    dt_wr_en, dt_rd_en;
    logic [IDX_W-1:0]        dt_wr_addr, dt_rd_addr;
    logic [DATA_WIDTH-1:0]   dt_wr_data, dt_rd_data;

    ple_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk     (aclk),
        .wr_en   (lk_wr_en),
        .wr_addr (lk_wr_addr),
        .wr_data (lk_wr_data),
        .rd_en   (lk_rd_en),
        .rd_addr (lk_rd_addr),
        .rd_data (lk_rd_data)
    );

    ple_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_data_ram (
        .clk     (aclk),
        .wr_en   (dt_wr_en),
        .wr_addr (dt_wr_addr),
        .wr_data (dt_wr_data),
        .rd_en   (dt_rd_en),
        .rd_addr (dt_rd_addr),
        .rd_data (dt_rd_data)
    );

    // Effective 1-based target position of the latched operation.
    always_comb begin
        unique case (op_reg)
            OP_INS_FRONT: eff_pos = CNT_W'(1);
            OP_INS_BACK:  eff_pos = count_reg + CNT_W'(1);
            OP_INS_AT:    eff_pos = pos_reg;
            OP_DEL_FRONT: eff_pos = CNT_W'(1);
            OP_DEL_BACK:  eff_pos = count_reg;
            OP_DEL_AT:    eff_pos = pos_reg;
            default:      eff_pos = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        tgt_next      = tgt_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ptr_next      = ptr_reg;
        steps_next    = steps_reg;
        node_next     = node_reg;
        ins_next      = ins_reg;
        tail_ld_next  = tail_ld_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_head_next   = m_head_reg;
        m_tail_next   = m_tail_reg;

        lk_wr_en   = 1'b0;
        lk_wr_addr = node_reg;
        lk_wr_data = free_reg;
        lk_rd_en   = 1'b0;
        lk_rd_addr = first_reg[IDX_W-1:0];
        dt_wr_en   = 1'b0;
        dt_wr_addr = node_reg;
        dt_wr_data = value_reg;
        dt_rd_en   = 1'b0;
        dt_rd_addr = ptr_reg[IDX_W-1:0];

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = op_t'(s_operation);
                    value_next  = s_value;
                    pos_next    = s_position;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                tgt_next = eff_pos;
                unique case (op_reg)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                        priority if (eff_pos == '0 || eff_pos > count_reg + CNT_W'(1)) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_DONE;
                        end else if (count_reg == CNT_W'(POOL_DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (free_reg != NIL) begin
                            // Pop the free chain: fetch the link of its head.
                            lk_rd_en   = 1'b1;
                            lk_rd_addr = free_reg[IDX_W-1:0];
                            node_next  = free_reg[IDX_W-1:0];
                            state_next = S_POP;
                        end else begin
                            node_next  = fresh_reg[IDX_W-1:0];
                            fresh_next = fresh_reg + PTR_W'(1);
                            state_next = S_INSERT;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                        priority if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else if (eff_pos == '0 || eff_pos > count_reg) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_DONE;
                        end else if (eff_pos == CNT_W'(1)) begin
                            lk_rd_en   = 1'b1;
                            lk_rd_addr = first_reg[IDX_W-1:0];
                            node_next  = first_reg[IDX_W-1:0];
                            state_next = S_DEL_FRONT;
                        end else begin
                            lk_rd_en   = 1'b1;
                            lk_rd_addr = first_reg[IDX_W-1:0];
                            ptr_next   = first_reg;
                            steps_next = eff_pos - CNT_W'(2);
                            ins_next   = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                    OP_CLEAR: begin
                        first_next = NIL;
                        last_next  = NIL;
                        free_next  = NIL;
                        count_next = '0;
                        fresh_next = '0;
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_POP: begin
                free_next  = lk_rd_data;
                state_next = S_INSERT;
            end

            S_INSERT: begin
                if (tgt_reg == CNT_W'(1)) begin
                    dt_wr_en   = 1'b1;
                    lk_wr_en   = 1'b1;
                    lk_wr_data = first_reg;
                    first_next = PTR_W'(node_reg);
                    head_next  = value_reg;
                    if (count_reg == '0) begin
                        last_next = PTR_W'(node_reg);
                        tail_next = value_reg;
                    end
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = first_reg[IDX_W-1:0];
                    ptr_next   = first_reg;
                    steps_next = tgt_reg - CNT_W'(2);
                    ins_next   = 1'b1;
                    state_next = S_WALK;
                end
            end

            // The link RAM output holds next[ptr]; follow it one node per cycle.
            S_WALK: begin
                if (steps_reg != '0) begin
                    ptr_next   = lk_rd_data;
                    steps_next = steps_reg - CNT_W'(1);
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = lk_rd_data[IDX_W-1:0];
                end else if (ins_reg) begin
                    lk_wr_en   = 1'b1;
                    lk_wr_data = lk_rd_data;
                    dt_wr_en   = 1'b1;
                    state_next = S_INS_LINK;
                end else begin
                    node_next  = lk_rd_data[IDX_W-1:0];
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = lk_rd_data[IDX_W-1:0];
                    state_next = S_DEL_NEXT;
                end
            end

            S_INS_LINK: begin
                lk_wr_en   = 1'b1;
                lk_wr_addr = ptr_reg[IDX_W-1:0];
                lk_wr_data = PTR_W'(node_reg);
                if (ptr_reg == last_reg) begin
                    last_next = PTR_W'(node_reg);
                    tail_next = value_reg;
                end
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DEL_NEXT: begin
                // Unlink the victim from its predecessor.
                lk_wr_en   = 1'b1;
                lk_wr_addr = ptr_reg[IDX_W-1:0];
                lk_wr_data = lk_rd_data;
                if (PTR_W'(node_reg) == last_reg) begin
                    last_next    = ptr_reg;
                    dt_rd_en     = 1'b1;
                    dt_rd_addr   = ptr_reg[IDX_W-1:0];
                    tail_ld_next = 1'b1;
                end else begin
                    tail_ld_next = 1'b0;
                end
                state_next = S_DEL_FREE;
            end

            S_DEL_FREE: begin
                lk_wr_en   = 1'b1;
                free_next  = PTR_W'(node_reg);
                count_next = count_reg - CNT_W'(1);
                if (tail_ld_reg) begin
                    tail_next = dt_rd_data;
                end
                state_next = S_DONE;
            end

            S_DEL_FRONT: begin
                lk_wr_en   = 1'b1;
                free_next  = PTR_W'(node_reg);
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    first_next = NIL;
                    last_next  = NIL;
                    state_next = S_DONE;
                end else begin
                    first_next = lk_rd_data;
                    dt_rd_en   = 1'b1;
                    dt_rd_addr = lk_rd_data[IDX_W-1:0];
                    state_next = S_DEL_HEAD;
                end
            end

            S_DEL_HEAD: begin
                head_next  = dt_rd_data;
                state_next = S_DONE;
            end

            S_DONE: begin
                // Hold until the result register is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    m_head_next   = (count_reg == '0) ? '0 : head_reg;
                    m_tail_next   = (count_reg == '0) ? '0 : tail_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            first_reg   <= NIL;
            last_reg    <= NIL;
            count_reg   <= '0;
            free_reg    <= NIL;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        pos_reg      <= pos_next;
        tgt_reg      <= tgt_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        ptr_reg      <= ptr_next;
        steps_reg    <= steps_next;
        node_reg     <= node_next;
        ins_reg      <= ins_next;
        tail_ld_reg  <= tail_ld_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_head_reg   <= m_head_next;
        m_tail_reg   <= m_tail_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;
    assign m_head_value = m_head_reg;
    assign m_tail_value = m_tail_reg;

    `PLE_ASSERT_ALWAYS(a_count_le_fresh, (PTR_W + 1)'(count_reg) <= (PTR_W + 1)'(fresh_reg), "list count exceeds nodes ever handed out")
    `PLE_ASSERT_ALWAYS(a_empty_head_null, (count_reg == '0) == (first_reg == NIL), "head pointer disagrees with list count")
    `PLE_ASSERT_NEXT(a_walk_advance, state_reg == S_WALK && steps_reg != '0, state_reg == S_WALK && steps_reg == $past(steps_reg) - CNT_W'(1), "link walk did not advance one node")
    `PLE_ASSERT_NEXT(a_result_hold, state_reg == S_DONE && m_valid_reg && !m_ready, state_reg == S_DONE, "pending result overwritten")

endmodule

// ===== verif/positional_list_engine_core_checker.sv =====
// Transaction checker for the positional list engine: list predictor and result comparison.
`timescale 1ns / 100ps

module positional_list_engine_core_checker
    import ple_pkg::*;
#(
    parameter int POOL_DEPTH = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [2:0]                      s_operation,
    input  logic signed [DATA_WIDTH-1:0]    s_value,
    input  logic [$clog2(POOL_DEPTH+2)-1:0] s_position,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_status,
    input  logic [$clog2(POOL_DEPTH+2)-1:0] m_count,
    input  logic signed [DATA_WIDTH-1:0]    m_head_value,
    input  logic signed [DATA_WIDTH-1:0]    m_tail_value,
    output int                              fail_count,
    output int                              pending,
    output int                              list_len
);

    localparam int CW = $clog2(POOL_DEPTH + 2);
    localparam int MAX_PRINTED = 200;

    typedef struct packed {
        status_t                      status;
        logic [CW-1:0]                count;
        logic signed [DATA_WIDTH-1:0] head;
        logic signed [DATA_WIDTH-1:0] tail;
    } list_result_t;

    // Values of the list in order, front first.
    logic signed [DATA_WIDTH-1:0] list_values[$];
    list_result_t                 expected_results[$];
    int                           results_seen;

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        fail_count++;
    endtask

    function automatic status_t insert_value(input int slot, input logic signed [DATA_WIDTH-1:0] v);
        if (slot < 1 || slot > list_values.size() + 1)
            return ST_BAD_POS;
        if (list_values.size() >= POOL_DEPTH)
            return ST_FULL;
        list_values.insert(slot - 1, v);
        return ST_OK;
    endfunction

    function automatic status_t remove_value(input int slot);
        if (list_values.size() == 0)
            return ST_EMPTY;
        if (slot < 1 || slot > list_values.size())
            return ST_BAD_POS;
        list_values.delete(slot - 1);
        return ST_OK;
    endfunction

    function automatic list_result_t apply_operation(input logic [2:0] op,
                                                     input logic signed [DATA_WIDTH-1:0] v,
                                                     input logic [CW-1:0] pos);
        list_result_t r;
        status_t      st;
        st = ST_OK;
        case (op)
            OP_INS_FRONT: st = insert_value(1, v);
            OP_INS_BACK:  st = insert_value(list_values.size() + 1, v);
            OP_INS_AT:    st = insert_value(int'(pos), v);
            OP_DEL_FRONT: st = remove_value(1);
            OP_DEL_BACK:  st = remove_value(list_values.size());
            OP_DEL_AT:    st = remove_value(int'(pos));
            OP_CLEAR:     list_values.delete();
            default:      st = ST_OK;
        endcase
        r.status = st;
        r.count  = CW'(list_values.size());
        r.head   = (list_values.size() == 0) ? '0 : list_values[0];
        r.tail   = (list_values.size() == 0) ? '0 : list_values[$];
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            fail_count   = 0;
            pending      = 0;
            list_len     = 0;
            results_seen = 0;
            list_values.delete();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no operation outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  m_count, want.count));
                    if (m_head_value !== want.head)
                        report_mismatch($sformatf("head %0d, expected %0d",
                                                  m_head_value, want.head));
                    if (m_tail_value !== want.tail)
                        report_mismatch($sformatf("tail %0d, expected %0d",
                                                  m_tail_value, want.tail));
                end
                results_seen++;
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_operation(s_operation, s_value, s_position));
            pending  = expected_results.size();
            list_len = list_values.size();
        end
    end

endmodule

// ===== verif/positional_list_engine_core_tb.sv =====
// Testbench top for the positional list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module positional_list_engine_core_tb
    import ple_pkg::*;
();

    localparam int POOL_DEPTH = 256;
    localparam int DATA_WIDTH = 32;
    localparam int CW         = $clog2(POOL_DEPTH + 2);
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [2:0]                   s_operation;
    logic signed [DATA_WIDTH-1:0] s_value;
    logic [CW-1:0]                s_position;
    logic                         m_valid;
    logic                         m_ready;
    logic [1:0]                   m_status;
    logic [CW-1:0]                m_count;
    logic signed [DATA_WIDTH-1:0] m_head_value;
    logic signed [DATA_WIDTH-1:0] m_tail_value;

    int fail_count;
    int pending;
    int list_len;
    int cycles = 0;
    bit no_idle;

    positional_list_engine_core #(
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_head_value (m_head_value),
        .m_tail_value (m_tail_value)
    );

    positional_list_engine_core_checker #(
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_head_value (m_head_value),
        .m_tail_value (m_tail_value),
        .fail_count   (fail_count),
        .pending      (pending),
        .list_len     (list_len)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall for a random number of cycles after each transaction, unless no_idle is set.
    initial begin
        bit took;
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            took = m_valid && m_ready;
            @(negedge aclk);
            if (took)
                stall_left = no_idle ? 0 : $urandom_range(0, 7);
            if (!aresetn || stall_left > 0) begin
                m_ready <= 1'b0;
                if (stall_left > 0)
                    stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input logic [2:0] op, input logic signed [DATA_WIDTH-1:0] v,
                           input logic [CW-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= v;
        s_position  <= pos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] draw_value();
        case ($urandom_range(0, 11))
            0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, with the edges and the whole field mixed in.
    function automatic logic [CW-1:0] draw_position(input bit for_insert);
        int top_pos;
        int r;
        top_pos = for_insert ? list_len + 1 : list_len;
        r = $urandom_range(0, 19);
        if (r < 14 && top_pos >= 1)
            return CW'($urandom_range(1, top_pos));
        else if (r < 16 && top_pos >= 1)
            return CW'(($urandom_range(0, 1) == 0) ? 1 : top_pos);
        else if (r < 17)
            return CW'(top_pos + 1);
        else if (r < 18)
            return '0;
        else
            return CW'($urandom_range(0, (1 << CW) - 1));
    endfunction

    function automatic logic [2:0] pick_op(input int insert_pct, input bit allow_clear);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0)
            return OP_UNUSED;
        if (r == 1 && allow_clear)
            return OP_CLEAR;
        if (r < insert_pct) begin
            case ($urandom_range(0, 2))
                0:       return OP_INS_FRONT;
                1:       return OP_INS_BACK;
                default: return OP_INS_AT;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       return OP_DEL_FRONT;
            1:       return OP_DEL_BACK;
            default: return OP_DEL_AT;
        endcase
    endfunction

    task automatic run_random(input int items, input int insert_pct, input bit allow_clear);
        logic [2:0] op;
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            op = pick_op(insert_pct, allow_clear);
            send_op(op, draw_value(), draw_position(op == OP_INS_AT));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_INS_FRONT;
        s_value     = '0;
        s_position  = '0;
        no_idle     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty list: every delete reports empty, even at a bad position.
        send_op(OP_DEL_FRONT, 32'sd7, 9'd0);
        send_op(OP_DEL_BACK, 32'sd7, 9'd0);
        send_op(OP_DEL_AT, 32'sd7, 9'd1);
        send_op(OP_DEL_AT, 32'sd7, 9'd0);
        send_op(OP_INS_AT, 32'sd9, 9'd0);
        send_op(OP_INS_AT, 32'sd9, 9'd2);
        // First insert becomes both head and tail.
        send_op(OP_INS_AT, 32'sh8000_0000, 9'd1);
        send_op(OP_INS_BACK, 32'sh7fff_ffff, 9'd0);
        send_op(OP_INS_FRONT, -32'sd1, 9'd0);
        send_op(OP_INS_AT, 32'sd0, 9'd4);
        send_op(OP_INS_AT, 32'sd1, 9'd2);
        send_op(OP_INS_AT, 32'sd2, 9'd511);
        send_op(OP_DEL_AT, 32'sd0, 9'd0);
        send_op(OP_DEL_AT, 32'sd0, 9'd6);
        send_op(OP_DEL_AT, 32'sd0, 9'd5);
        send_op(OP_DEL_AT, 32'sd0, 9'd2);
        send_op(OP_DEL_BACK, 32'sd0, 9'd0);
        send_op(OP_UNUSED, 32'sh1234_5678, 9'd256);
        send_op(OP_CLEAR, 32'sd0, 9'd0);
        send_op(OP_DEL_BACK, 32'sd0, 9'd0);
        send_op(OP_INS_BACK, 32'sh5555_5555, 9'd0);
        send_op(OP_INS_FRONT, 32'shaaaa_aaaa, 9'd0);
        send_op(OP_CLEAR, 32'sd0, 9'd0);
        send_op(OP_INS_FRONT, 32'sd42, 9'd0);
        send_op(OP_DEL_BACK, 32'sd0, 9'd0);

        // Fill past full, drain past empty, then a mixed stretch with clears.
        run_random(420, 90, 1'b0);
        run_random(400, 10, 1'b0);
        run_random(480, 55, 1'b1);

        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (POOL_DEPTH + 16) @(negedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
